// ===== sv/sync_length_checksum_deframer_defines.svh =====
// Assertion macros for the sync, length and checksum deframer.
// Uses clk and arst_n from the module that includes this header.
// No other dependencies.
`ifndef SYNC_LENGTH_CHECKSUM_DEFRAMER_DEFINES_SVH
`define SYNC_LENGTH_CHECKSUM_DEFRAMER_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define SLD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SLD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/sld_pkg.sv =====
// Shared types and constants for the sync, length and checksum deframer.
// No dependencies; used by the channel interfaces and the top level.
package sld_pkg;

	localparam int ByteW = 8;
	localparam int RunW  = 4;

	typedef logic [ByteW-1:0] byte_t;
	typedef logic [RunW-1:0]  run_t;

	// Register indexes of the configuration port.
	typedef enum logic [1:0] {
		CFG_SYNC_VALUE  = 2'd0,
		CFG_SYNC_NEEDED = 2'd1,
		CFG_MIN_LENGTH  = 2'd2,
		CFG_MAX_LENGTH  = 2'd3
	} cfg_idx_t;

	localparam byte_t RST_SYNC_VALUE  = 8'hAA;
	localparam run_t  RST_SYNC_NEEDED = 4'd4;
	localparam byte_t RST_MIN_LENGTH  = 8'd3;
	localparam byte_t RST_MAX_LENGTH  = 8'd10;
	localparam run_t  RUN_MAX         = 4'd15;

	localparam logic STATUS_GOOD = 1'b0;
	localparam logic STATUS_BAD  = 1'b1;

endpackage

// ===== sv/sld_ifs.sv =====
// Valid/ready channel interfaces for the deframer: received bytes,
// results and configuration writes. Depends on sld_pkg.

interface sld_byte_if;
	logic           valid;
	logic           ready;
	sld_pkg::byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface sld_res_if;
	logic           valid;
	logic           ready;
	logic           packet_status;
	sld_pkg::byte_t message_id;
	sld_pkg::byte_t packet_length;

	modport source (output valid, output packet_status, output message_id,
		output packet_length, input ready);
	modport sink (input valid, input packet_status, input message_id,
		input packet_length, output ready);
endinterface

interface sld_cfg_if;
	logic              valid;
	logic              ready;
	sld_pkg::cfg_idx_t index;
	sld_pkg::byte_t    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/sync_length_checksum_deframer.sv =====
// Sync, length and additive-checksum packet deframer, top level.
// Depends on sld_pkg, the interfaces in sld_ifs.sv and the assertion header.
//
//   channel  direction  payload                                    word
//   rx       in         rx_byte                                    one received byte
//   res      out        packet_status, message_id, packet_length   one finished packet
//   cfg      in         index, data                                one register write
//
// The framing state is updated at the edge that accepts a byte, and a
// finished packet is loaded into the result register there.
// A byte is taken every cycle while the result register is empty or being read.
// Reset clears the framing state and the result valid flag and loads the configuration
// registers with their reset values; the held message id, declared length and result fields have no reset.
// cfg is always ready and writes in the cycle it is offered.
`include "sync_length_checksum_deframer_defines.svh"

module sync_length_checksum_deframer (
	input  logic  clk,
	input  logic  arst_n,
	sld_byte_if.sink  rx,
	sld_res_if.source res,
	sld_cfg_if.sink   cfg
);
	import sld_pkg::*;

	byte_t sync_value_q;
	run_t  sync_needed_q;
	byte_t min_length_q;
	byte_t max_length_q;

	logic  in_sync_q;
	run_t  sync_run_q;
	byte_t byte_count_q;
	byte_t running_sum_q;
	byte_t held_id_q;
	byte_t declared_length_q;

	logic  out_valid_q;
	logic  out_status_q;
	byte_t out_id_q;
	byte_t out_len_q;

	logic  acc;
	logic  is_sync;
	run_t  run_inc;
	run_t  run_next;
	logic  restart;
	logic  active;
	logic  overflow;
	logic  store;
	byte_t count_inc;
	byte_t sum_next;
	byte_t id_now;
	byte_t len_now;
	logic  emit;
	logic  bad;

	assign rx.ready  = !out_valid_q || res.ready;
	assign acc       = rx.valid && rx.ready;
	assign cfg.ready = 1'b1;

	always_comb begin
		is_sync   = (rx.rx_byte == sync_value_q);
		run_inc   = (sync_run_q != RUN_MAX) ? sync_run_q + run_t'(1) : sync_run_q;
		run_next  = is_sync ? run_inc : '0;
		restart   = is_sync && (run_inc >= sync_needed_q);
		active    = !restart && in_sync_q;
		overflow  = active && (byte_count_q == max_length_q);
		store     = active && !overflow;
		count_inc = byte_count_q + byte_t'(1);
		sum_next  = running_sum_q + rx.rx_byte;
		id_now    = (byte_count_q == '0) ? rx.rx_byte : held_id_q;
		len_now   = (byte_count_q == byte_t'(1)) ? rx.rx_byte : declared_length_q;
		emit      = store && (count_inc >= min_length_q) && (count_inc == len_now);
		bad       = (sum_next != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_value_q  <= RST_SYNC_VALUE;
			sync_needed_q <= RST_SYNC_NEEDED;
			min_length_q  <= RST_MIN_LENGTH;
			max_length_q  <= RST_MAX_LENGTH;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_SYNC_VALUE:  sync_value_q  <= cfg.data;
				CFG_SYNC_NEEDED: sync_needed_q <= cfg.data[RunW-1:0];
				CFG_MIN_LENGTH:  min_length_q  <= cfg.data;
				CFG_MAX_LENGTH:  max_length_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sync_q     <= 1'b0;
			sync_run_q    <= '0;
			byte_count_q  <= '0;
			running_sum_q <= '0;
		end else if (acc) begin
			sync_run_q <= run_next;
			if (restart) begin
				in_sync_q     <= 1'b1;
				byte_count_q  <= '0;
				running_sum_q <= '0;
			end else if (overflow) begin
				in_sync_q     <= 1'b0;
				byte_count_q  <= '0;
				running_sum_q <= '0;
			end else if (store) begin
				if (emit) begin
					// A checksum error drops sync; the count restarts either way.
					in_sync_q     <= !bad;
					byte_count_q  <= '0;
					running_sum_q <= '0;
				end else begin
					byte_count_q  <= count_inc;
					running_sum_q <= sum_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && store) begin
			held_id_q         <= id_now;
			declared_length_q <= len_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc && emit) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && emit) begin
			out_status_q <= bad ? STATUS_BAD : STATUS_GOOD;
			out_id_q     <= id_now;
			out_len_q    <= count_inc;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.packet_status = out_status_q;
	assign res.message_id    = out_id_q;
	assign res.packet_length = out_len_q;

	`SLD_ASSERT_IMP(a_count_idle, !in_sync_q, byte_count_q == '0, "count held while out of sync")
	`SLD_ASSERT_IMP(a_emit_in_sync, emit, in_sync_q, "packet finished while out of sync")
	`SLD_ASSERT_NEXT(a_bad_drops_sync, acc && emit && bad, !in_sync_q && out_valid_q, "checksum error kept sync")

endmodule

// ===== tb/sld_frame_checker.sv =====
// Checker for the deframer: watches the byte, result and configuration channels,
// predicts each finished packet and compares it with what the block delivers.
// Depends on sld_pkg and the channel interfaces in sld_ifs.sv.
module sld_frame_checker (
	input  logic clk,
	input  logic arst_n,
	sld_byte_if  rx,
	sld_res_if   res,
	sld_cfg_if   cfg,
	output int   errors,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import sld_pkg::*;

	typedef struct packed {
		logic  status;
		byte_t id;
		byte_t len;
	} packet_sum_t;

	packet_sum_t packets_due[$];
	packet_sum_t oldest;
	int          fail_count = 0;

	// Configuration as the block should hold it.
	byte_t sync_val;
	run_t  need;
	byte_t min_len;
	byte_t max_len;

	// Framing state.
	logic  synced;
	run_t  run;
	byte_t frame_count;
	byte_t frame_sum;
	byte_t id_held;
	byte_t len_held;

	assign errors = fail_count;

	task automatic report(input string msg);
		$display("%0t ns checker: %s", $realtime, msg);
		fail_count++;
	endtask

	// Applies one received byte to the framing state and queues the packet it finishes.
	task automatic frame_byte(input byte_t b);
		packet_sum_t p;
		if (b == sync_val) begin
			if (run != RUN_MAX)
				run = run + 1'b1;
			if (run >= need) begin
				synced = 1'b1;
				frame_count = '0;
				frame_sum = '0;
				return;
			end
		end else begin
			run = '0;
		end
		if (!synced)
			return;
		// A byte beyond the longest allowed packet is thrown away with the sync.
		if (frame_count == max_len) begin
			synced = 1'b0;
			frame_count = '0;
			frame_sum = '0;
			return;
		end
		if (frame_count == 8'd0)
			id_held = b;
		else if (frame_count == 8'd1)
			len_held = b;
		frame_sum = frame_sum + b;
		frame_count = frame_count + 1'b1;
		if (frame_count >= min_len && frame_count == len_held) begin
			p.status = (frame_sum != 8'd0) ? STATUS_BAD : STATUS_GOOD;
			p.id = id_held;
			p.len = frame_count;
			packets_due.push_back(p);
			frame_count = '0;
			frame_sum = '0;
			if (p.status == STATUS_BAD)
				synced = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_val = RST_SYNC_VALUE;
			need = RST_SYNC_NEEDED;
			min_len = RST_MIN_LENGTH;
			max_len = RST_MAX_LENGTH;
			synced = 1'b0;
			run = '0;
			frame_count = '0;
			frame_sum = '0;
			id_held = '0;
			len_held = '0;
			packets_due.delete();
			pending <= 0;
		end else begin
			// The result taken at this edge is always older than any byte taken with it.
			if (res.valid && res.ready) begin
				if (packets_due.size() == 0) begin
					report($sformatf("packet with none due: status %0b id %02h length %0d",
						res.packet_status, res.message_id, res.packet_length));
				end else begin
					oldest = packets_due.pop_front();
					if (res.packet_status !== oldest.status)
						report($sformatf("status %0b, wanted %0b", res.packet_status,
							oldest.status));
					if (res.message_id !== oldest.id)
						report($sformatf("message id %02h, wanted %02h", res.message_id,
							oldest.id));
					if (res.packet_length !== oldest.len)
						report($sformatf("length %0d, wanted %0d", res.packet_length,
							oldest.len));
				end
			end
			if (rx.valid && rx.ready)
				frame_byte(rx.rx_byte);
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_SYNC_VALUE: sync_val = cfg.data;
					CFG_SYNC_NEEDED: need = cfg.data[RunW-1:0];
					CFG_MIN_LENGTH: min_len = cfg.data;
					CFG_MAX_LENGTH: max_len = cfg.data;
					default: ;
				endcase
			end
			pending <= packets_due.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// Top of the deframer testbench: clock, reset, byte and configuration stimulus,
// result-side back-pressure, a watchdog and the verdict.
// Depends on sld_pkg, sld_ifs.sv, the block and sld_frame_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sld_pkg::*;

	localparam int IdleLimit = 3000;
	localparam int HoldCycles = 300;

	logic clk;
	logic arst_n;
	int   err_count;
	int   pending;
	int   sent = 0;
	int   idle_cycles = 0;
	bit   idling_on = 1'b1;
	bit   hold_req = 1'b0;

	byte_t cur_sync = RST_SYNC_VALUE;
	run_t  cur_need = RST_SYNC_NEEDED;
	byte_t cur_min = RST_MIN_LENGTH;
	byte_t cur_max = RST_MAX_LENGTH;

	sld_byte_if rx_ch ();
	sld_res_if  res_ch ();
	sld_cfg_if  cfg_ch ();

	sync_length_checksum_deframer DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_ch),
		.res   (res_ch),
		.cfg   (cfg_ch)
	);

	sld_frame_checker u_checker (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch),
		.cfg    (cfg_ch),
		.errors (err_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Nothing accepted on any channel for too long means the block has hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	// Result side: random stalls, and one long hold-off on request.
	initial begin
		res_ch.ready = 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
			end else if (idling_on && $urandom_range(0, 4) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Offers one byte and returns at the edge that takes it; valid stays high.
	task automatic send_byte(input byte_t b);
		if (idling_on && $urandom_range(0, 5) == 0) begin
			rx_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		do
			@(posedge clk);
		while (!rx_ch.ready);
		sent++;
	endtask

	task automatic send_run(input int n);
		repeat (n) send_byte(cur_sync);
	endtask

	// Sends id, length, payload and, for a length of three or more, a closing checksum byte that zeroes the sum,
	// or spoils it when bad is set.
	task automatic send_packet(input byte_t id, input int len, input bit bad);
		byte_t total;
		byte_t b;
		int    i;
		total = id + byte_t'(len);
		send_byte(id);
		send_byte(byte_t'(len));
		for (i = 2; i < len - 1; i++) begin
			b = ($urandom_range(0, 7) == 0) ? cur_sync : byte_t'($urandom_range(0, 255));
			total = total + b;
			send_byte(b);
		end
		if (len >= 3) begin
			b = -total;
			if (bad)
				b = b + byte_t'($urandom_range(1, 255));
			send_byte(b);
		end
	endtask

	// Mostly the run the block needs, sometimes longer, now and then past saturation.
	function automatic int pick_run_len();
		int r;
		int base;
		r = $urandom_range(0, 19);
		base = (cur_need == 0) ? 1 : int'(cur_need);
		if (r == 0)
			return $urandom_range(16, 18);
		if (r < 4)
			return base + $urandom_range(1, 3);
		return base;
	endfunction

	// Stops offering bytes and waits until every predicted packet has been read.
	task automatic wait_idle();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input byte_t val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
	endtask

	task automatic set_config(input byte_t sv, input run_t nd, input byte_t mn,
			input byte_t mx);
		wait_idle();
		write_reg(CFG_SYNC_VALUE, sv);
		write_reg(CFG_SYNC_NEEDED, byte_t'(nd));
		write_reg(CFG_MIN_LENGTH, mn);
		write_reg(CFG_MAX_LENGTH, mx);
		cfg_ch.valid <= 1'b0;
		cur_sync = sv;
		cur_need = nd;
		cur_min = mn;
		cur_max = mx;
	endtask

	task automatic random_phase(input int n);
		int    stop;
		int    pick;
		int    lo;
		int    hi;
		int    len;
		bit    bad;
		byte_t id;
		stop = sent + n;
		while (sent < stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				if ($urandom_range(0, 9) < 6)
					send_run(pick_run_len());
				lo = (cur_min < 2) ? 2 : int'(cur_min);
				hi = cur_max;
				if (hi < lo)
					hi = (lo + 3 > 255) ? 255 : lo + 3;
				else if (hi > lo + 12 && $urandom_range(0, 49) != 0)
					hi = lo + 12;
				len = $urandom_range(lo, hi);
				bad = ($urandom_range(0, 6) == 0);
				id = byte_t'($urandom_range(0, 255));
				// A two-byte packet can only be good when id and length sum to zero.
				if (len == 2 && !bad)
					id = 8'hFE;
				send_packet(id, len, bad);
			end else if (pick < 80) begin
				if (cur_need > 1)
					send_run(cur_need - 1);
				repeat ($urandom_range(1, 4)) send_byte(byte_t'($urandom_range(0, 255)));
			end else if (pick < 90) begin
				if (cur_min < 2 && $urandom_range(0, 1) == 0) begin
					// Declare a length of one, then the next id byte alone finishes a packet.
					send_run(pick_run_len());
					send_byte(byte_t'($urandom_range(0, 255)));
					send_byte(8'd1);
					send_run(pick_run_len());
					send_byte(byte_t'($urandom_range(0, 255)));
				end else begin
					repeat ($urandom_range(1, 8)) send_byte(byte_t'($urandom_range(0, 255)));
				end
			end else if (cur_max < 40) begin
				// Declared length beyond the limit runs into the overflow.
				send_run(pick_run_len());
				send_byte(byte_t'($urandom_range(0, 255)));
				send_byte(byte_t'($urandom_range(cur_max + 1, 255)));
				repeat (cur_max) send_byte(byte_t'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 8)) send_byte(byte_t'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_SYNC_VALUE;
		cfg_ch.data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words under the reset settings. The first packet also sets
		// the declared length before any setting with a short minimum.
		send_run(4);
		send_packet(8'h00, 3, 1'b0);
		send_packet(8'h12, 3, 1'b1);
		send_run(3);
		send_byte(8'h00);
		send_run(4);
		send_byte(8'h33);
		send_byte(8'd20);
		repeat (9) send_byte(byte_t'($urandom_range(0, 255)));
		send_run(4);
		send_packet(8'hFF, 10, 1'b0);

		// The result side holds off while bytes keep coming.
		wait_idle();
		hold_req = 1'b1;
		random_phase(180);

		set_config(8'h00, 4'd1, 8'd2, 8'd2);
		idling_on = 1'b0;
		random_phase(100);
		idling_on = 1'b1;
		set_config(8'hFF, 4'd15, 8'd5, 8'd30);
		random_phase(180);
		set_config(8'h5A, 4'd0, 8'd3, 8'd12);
		random_phase(130);
		set_config(8'hAA, 4'd3, 8'd0, 8'd8);
		random_phase(130);
		set_config(8'h3C, 4'd2, 8'd1, 8'd6);
		idling_on = 1'b0;
		random_phase(120);
		idling_on = 1'b1;
		set_config(8'hC3, 4'd4, 8'd4, 8'd0);
		random_phase(50);
		set_config(byte_t'($urandom_range(0, 255)), run_t'($urandom_range(1, 15)),
			byte_t'($urandom_range(2, 20)), byte_t'($urandom_range(20, 40)));
		random_phase(130);
		set_config(8'h81, 4'd2, 8'd255, 8'd255);
		random_phase(320);

		// Closing stretch without any idling.
		idling_on = 1'b0;
		set_config(8'h7E, 4'd1, 8'd2, 8'd255);
		random_phase(120);
		set_config(byte_t'($urandom_range(0, 255)), run_t'($urandom_range(1, 15)), 8'd3,
			8'd16);
		random_phase(120);

		wait_idle();
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
